[rtl/core/mcpq_pkg.sv]
// shared types and constants of the midi command packer queue
`default_nettype none

package mcpq_pkg;

    localparam int WORD_W  = 24;
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 14;
    localparam int CTYPE_W = 5;
    localparam int BYTE_W  = 8;
    localparam int ID_W    = 12;

    localparam logic [REQ_W-1:0] REQ_VOICE = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PARAM = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TIME  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CURVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEST  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_SEND  = 3'd5;

    localparam logic [WORD_W-1:0] ST_VOICE = 24'h800000;
    localparam logic [WORD_W-1:0] ST_PARAM = 24'h804000;
    localparam logic [WORD_W-1:0] ST_TIME  = 24'h900000;
    localparam logic [WORD_W-1:0] ST_CURVE = 24'hA00000;
    localparam logic [WORD_W-1:0] ST_DEST  = 24'hB00000;

    typedef struct packed {
        logic              push;
        logic [WORD_W-1:0] word;
    } push_req_t;

    typedef enum logic [1:0] {
        BYTE_STATUS,
        BYTE_HIGH,
        BYTE_LOW
    } byte_sel_t;

endpackage

`default_nettype wire

[rtl/core/midi_command_packer_queue_top.sv]
// top level of the midi command packer queue
// Commands are taken into an input register and packed in the next cycle; one write
// command can be accepted every cycle unless a send is waiting in the input register.
// A send pops the oldest word from the ring queue memory (registered read) and the
// serialiser emits its three bytes, status first, at one per cycle while m_ready is
// high, with the third marked last. A send waits in the input register while the
// previous word is still being emitted. A send on an empty queue is dropped; writes
// onto a full queue overwrite the oldest entry.
`default_nettype none

module midi_command_packer_queue_top
    import mcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [REQ_W-1:0]   s_req_type,
    input  wire logic [VALUE_W-1:0] s_value,
    input  wire logic [CTYPE_W-1:0] s_curve_type,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [BYTE_W-1:0]       m_out_byte,
    output logic                    m_last_byte
);

    logic               in_valid_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CTYPE_W-1:0] ctype_reg;

    logic              is_send;
    logic              go;
    logic              fire;
    logic              pop;
    logic              holds_words;
    logic              ser_free;
    logic [WORD_W-1:0] rd_word;
    push_req_t         push_req;

    assign is_send = (req_reg == REQ_SEND);
    assign go      = !is_send || !holds_words || ser_free;
    assign fire    = in_valid_reg && go;
    assign pop     = fire && is_send && holds_words;
    assign s_ready = !in_valid_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg   <= s_req_type;
            value_reg <= s_value;
            ctype_reg <= s_curve_type;
        end
    end

    mcpq_packer u_packer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .req_type   (req_reg),
        .value      (value_reg),
        .curve_type (ctype_reg),
        .push_req   (push_req)
    );

    mcpq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_req    (push_req),
        .pop         (pop),
        .holds_words (holds_words),
        .rd_word     (rd_word)
    );

    mcpq_serializer u_serializer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (pop),
        .word        (rd_word),
        .free        (ser_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

endmodule

`default_nettype wire

[rtl/core/mcpq_packer.sv]
// command packing into 24-bit words and repeat filtering of selects
`default_nettype none

module mcpq_packer
    import mcpq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [CTYPE_W-1:0] curve_type,
    output push_req_t               push_req
);

    logic [ID_W-1:0] last_voice_reg, last_voice_next;
    logic            voice_seen_reg, voice_seen_next;
    logic [ID_W-1:0] last_param_reg, last_param_next;
    logic            param_seen_reg, param_seen_next;
    logic [ID_W-1:0] id;

    function automatic logic [WORD_W-1:0] split12(input logic [ID_W-1:0] x);
        return {8'h00, 3'b000, x[11:7], 1'b0, x[6:0]};
    endfunction

    function automatic logic [WORD_W-1:0] split14(input logic [VALUE_W-1:0] x);
        return {8'h00, 1'b0, x[13:7], 1'b0, x[6:0]};
    endfunction

    assign id = value[ID_W-1:0];

    always_comb begin
        last_voice_next = last_voice_reg;
        voice_seen_next = voice_seen_reg;
        last_param_next = last_param_reg;
        param_seen_next = param_seen_reg;
        push_req.push   = 1'b0;
        push_req.word   = '0;
        unique case (req_type)
            REQ_VOICE: begin
                push_req.word = ST_VOICE | split12(id);
                if (!voice_seen_reg || id != last_voice_reg) begin
                    push_req.push = fire;
                    if (fire) begin
                        last_voice_next = id;
                        voice_seen_next = 1'b1;
                    end
                end
            end
            REQ_PARAM: begin
                push_req.word = ST_PARAM | split12(id);
                if (!param_seen_reg || id != last_param_reg) begin
                    push_req.push = fire;
                    if (fire) begin
                        last_param_next = id;
                        param_seen_next = 1'b1;
                    end
                end
            end
            REQ_TIME: begin
                push_req.word = ST_TIME | split14(value);
                push_req.push = fire;
            end
            REQ_CURVE: begin
                push_req.word = ST_CURVE
                              | {8'h00, 1'b0, curve_type, value[8:7], 1'b0, value[6:0]};
                push_req.push = fire;
            end
            REQ_DEST: begin
                push_req.word = ST_DEST | split14(value);
                push_req.push = fire;
            end
            default: begin
                push_req.push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_voice_reg <= '0;
            voice_seen_reg <= 1'b0;
            last_param_reg <= '0;
            param_seen_reg <= 1'b0;
        end else begin
            last_voice_reg <= last_voice_next;
            voice_seen_reg <= voice_seen_next;
            last_param_reg <= last_param_next;
            param_seen_reg <= param_seen_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mcpq_queue.sv]
// ring queue of packed words with registered read port
`default_nettype none

module mcpq_queue
    import mcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  push_req_t              push_req,
    input  wire logic              pop,
    output logic                   holds_words,
    output logic [WORD_W-1:0]      rd_word
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

    logic [WORD_W-1:0] mem_array [QUEUE_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic              holds_reg, holds_next;
    logic [IDX_W-1:0]  rd_idx_inc;

    assign rd_idx_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_ONE;

    always_comb begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        holds_next  = holds_reg;
        if (push_req.push) begin
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + IDX_ONE;
            holds_next  = 1'b1;
        end else if (pop) begin
            rd_idx_next = rd_idx_inc;
            holds_next  = (rd_idx_inc != wr_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            holds_reg  <= 1'b0;
        end else begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            holds_reg  <= holds_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_req.push) begin
            mem_array[wr_idx_reg] <= push_req.word;
        end
        if (pop) begin
            rd_data_reg <= mem_array[rd_idx_reg];
        end
    end

    assign holds_words = holds_reg;
    assign rd_word     = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/mcpq_serializer.sv]
// byte serialiser for one dequeued word
`default_nettype none

module mcpq_serializer
    import mcpq_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic [WORD_W-1:0] word,
    output logic                   free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_last_byte
);

    logic      busy_reg, busy_next;
    byte_sel_t sel_reg, sel_next;

    assign free = !busy_reg || (sel_reg == BYTE_LOW && m_ready);

    always_comb begin
        busy_next   = busy_reg;
        sel_next    = sel_reg;
        m_out_byte  = word[23:16];
        m_last_byte = 1'b0;
        unique case (sel_reg)
            BYTE_STATUS: begin
                m_out_byte = word[23:16];
                if (busy_reg && m_ready) begin
                    sel_next = BYTE_HIGH;
                end
            end
            BYTE_HIGH: begin
                m_out_byte = word[15:8];
                if (busy_reg && m_ready) begin
                    sel_next = BYTE_LOW;
                end
            end
            BYTE_LOW: begin
                m_out_byte  = word[7:0];
                m_last_byte = 1'b1;
                if (busy_reg && m_ready) begin
                    busy_next = 1'b0;
                    sel_next  = BYTE_STATUS;
                end
            end
            default: begin
                sel_next = BYTE_STATUS;
            end
        endcase
        if (load) begin
            busy_next = 1'b1;
            sel_next  = BYTE_STATUS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sel_reg  <= BYTE_STATUS;
        end else begin
            busy_reg <= busy_next;
            sel_reg  <= sel_next;
        end
    end

    assign m_valid = busy_reg;

endmodule

`default_nettype wire

[rtl/core/mcpq_checker.sv]
// port-level checker of the midi command packer queue and its bind
`default_nettype none

module mcpq_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_last_byte
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last_byte))
        else $error("output transaction changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // bytes of one word follow without a gap
    a_word_contig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_byte |=> m_valid)
        else $error("gap inside a word");

    a_last_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_byte |=> !(m_valid && m_last_byte))
        else $error("two last bytes in a row");

    a_low_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> !m_out_byte[7])
        else $error("low data byte has top bit set");

endmodule

bind midi_command_packer_queue_top mcpq_checker u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_last_byte (m_last_byte)
);

`default_nettype wire

[tb/midi_command_packer_queue_checker.sv]
// checker for the midi command packer queue: predicts the byte stream and compares it
`timescale 1ns / 100ps

module midi_command_packer_queue_checker
    import mcpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [REQ_W-1:0]   s_req_type,
    input  wire logic [VALUE_W-1:0] s_value,
    input  wire logic [CTYPE_W-1:0] s_curve_type,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [BYTE_W-1:0]  m_out_byte,
    input  wire logic               m_last_byte,
    output int                      errors,
    output int                      pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_last;
    } midi_byte_t;

    logic [WORD_W-1:0] word_ring [QUEUE_DEPTH];
    int                ring_rd;
    int                ring_wr;
    logic              ring_holds;
    logic [ID_W-1:0]   last_voice_id;
    logic              voice_sent;
    logic [ID_W-1:0]   last_param_id;
    logic              param_sent;

    midi_byte_t bytes_due [$];
    midi_byte_t due;
    int         err_count = 0;
    int         due_count = 0;

    assign errors  = err_count;
    assign pending = due_count;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t checker: %s", $time, msg);
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w);
        word_ring[ring_wr] = w;
        ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
        ring_holds = 1'b1;
    endtask

    task automatic pack_command(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                input logic [CTYPE_W-1:0] ctype);
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] w;
        id = val[ID_W-1:0];
        case (req)
            REQ_VOICE: begin
                if (!voice_sent || id != last_voice_id) begin
                    push_word(ST_VOICE | {11'd0, id[11:7], 1'b0, id[6:0]});
                    last_voice_id = id;
                    voice_sent = 1'b1;
                end
            end
            REQ_PARAM: begin
                if (!param_sent || id != last_param_id) begin
                    push_word(ST_PARAM | {11'd0, id[11:7], 1'b0, id[6:0]});
                    last_param_id = id;
                    param_sent = 1'b1;
                end
            end
            REQ_TIME: begin
                push_word(ST_TIME | {9'd0, val[13:7], 1'b0, val[6:0]});
            end
            REQ_CURVE: begin
                push_word(ST_CURVE | {9'd0, ctype, val[8:7], 1'b0, val[6:0]});
            end
            REQ_DEST: begin
                push_word(ST_DEST | {9'd0, val[13:7], 1'b0, val[6:0]});
            end
            REQ_SEND: begin
                if (ring_holds) begin
                    w = word_ring[ring_rd];
                    bytes_due.push_back('{data: w[23:16], is_last: 1'b0});
                    bytes_due.push_back('{data: w[15:8], is_last: 1'b0});
                    bytes_due.push_back('{data: w[7:0], is_last: 1'b1});
                    ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
                    if (ring_rd == ring_wr)
                        ring_holds = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ring_rd = 0;
            ring_wr = 0;
            ring_holds = 1'b0;
            last_voice_id = '0;
            voice_sent = 1'b0;
            last_param_id = '0;
            param_sent = 1'b0;
            bytes_due.delete();
        end else begin
            if (s_valid && s_ready)
                pack_command(s_req_type, s_value, s_curve_type);
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              m_out_byte, m_last_byte));
                end else begin
                    due = bytes_due.pop_front();
                    if (m_out_byte !== due.data)
                        report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                                  m_out_byte, due.data));
                    if (m_last_byte !== due.is_last)
                        report_mismatch($sformatf("last_byte %0b, predicted %0b",
                                                  m_last_byte, due.is_last));
                end
            end
        end
        due_count = bytes_due.size();
    end

endmodule

[tb/tb_midi_command_packer_queue_top.sv]
// testbench top of the midi command packer queue: stimulus and verdict
`timescale 1ns / 100ps

module tb_midi_command_packer_queue_top;
    import mcpq_pkg::*;

    localparam int QUEUE_DEPTH = 32;
    localparam int TARGET_ITEMS = 420;
    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [REQ_W-1:0]   s_req_type = REQ_SEND;
    logic [VALUE_W-1:0] s_value = '0;
    logic [CTYPE_W-1:0] s_curve_type = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [BYTE_W-1:0]  m_out_byte;
    logic               m_last_byte;

    int              errors;
    int              pending;
    bit              calm = 1'b0;
    int              items_sent = 0;
    int              bursts = 0;
    logic [ID_W-1:0] last_voice_val = '0;
    logic [ID_W-1:0] last_param_val = '0;

    midi_command_packer_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .s_curve_type(s_curve_type),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte)
    );

    midi_command_packer_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_value     (s_value),
        .s_curve_type(s_curve_type),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_last_byte (m_last_byte),
        .errors      (errors),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_midi_command_packer_queue_top: errors");
        $finish;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 17);
    end

    task automatic issue_command(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                 input logic [CTYPE_W-1:0] ct);
        if (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_value      <= val;
        s_curve_type <= ct;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (req == REQ_VOICE)
            last_voice_val = val[ID_W-1:0];
        if (req == REQ_PARAM)
            last_param_val = val[ID_W-1:0];
        if (req <= REQ_SEND)
            items_sent++;
    endtask

    // hold off until the result channel has caught up
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic random_command(input bit writes_only);
        logic [REQ_W-1:0]   req;
        logic [VALUE_W-1:0] val;
        logic [CTYPE_W-1:0] ct;
        int                 pick;
        pick = writes_only ? 99 : $urandom_range(99);
        if (pick < 4)
            req = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        else if (pick < 40)
            req = REQ_SEND;
        else
            req = REQ_W'($urandom_range(REQ_DEST, REQ_VOICE));
        case ($urandom_range(9))
            0:       val = '0;
            1:       val = '1;
            default: val = VALUE_W'($urandom());
        endcase
        ct = CTYPE_W'($urandom());
        // repeated selects, with random bits above the id
        if ($urandom_range(99) < 30) begin
            if (req == REQ_VOICE)
                val[ID_W-1:0] = last_voice_val;
            if (req == REQ_PARAM)
                val[ID_W-1:0] = last_param_val;
        end
        issue_command(req, val, ct);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        issue_command(REQ_SEND, '0, '0);
        issue_command(REQ_SPARE_LO, '1, '1);
        issue_command(REQ_SPARE_HI, '0, '0);
        issue_command(REQ_VOICE, 14'h0000, '0);
        issue_command(REQ_VOICE, 14'h0000, '1);
        issue_command(REQ_VOICE, 14'h3FFF, '0);
        issue_command(REQ_VOICE, 14'h2FFF, '0);
        issue_command(REQ_PARAM, 14'h0000, '0);
        issue_command(REQ_PARAM, 14'h0000, '0);
        issue_command(REQ_PARAM, 14'h3FFF, '0);
        issue_command(REQ_PARAM, 14'h1FFF, '1);
        issue_command(REQ_TIME, 14'h0000, '0);
        issue_command(REQ_TIME, 14'h3FFF, '1);
        issue_command(REQ_CURVE, 14'h3FFF, 5'h1F);
        issue_command(REQ_CURVE, 14'h0000, 5'h00);
        issue_command(REQ_CURVE, 14'h02AB, 5'h15);
        issue_command(REQ_DEST, 14'h3FFF, '0);
        issue_command(REQ_DEST, 14'h0000, '1);
        issue_command(REQ_DEST, 14'h2AAA, '0);
        repeat (5) issue_command(REQ_SEND, '1, '1);
        wait_drained();

        while (items_sent < TARGET_ITEMS) begin
            calm = (items_sent >= 200 && items_sent < 280);
            if ((bursts == 0 && items_sent >= 120) || (bursts == 1 && items_sent >= 330)) begin
                // overfill the ring, then empty it and send once more on empty
                repeat ($urandom_range(40, 33)) random_command(1'b1);
                repeat (QUEUE_DEPTH + 2)
                    issue_command(REQ_SEND, VALUE_W'($urandom()), CTYPE_W'($urandom()));
                wait_drained();
                bursts++;
            end else begin
                random_command(1'b0);
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("tb_midi_command_packer_queue_top: clean");
        else
            $display("tb_midi_command_packer_queue_top: errors");
        $finish;
    end

endmodule
